/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in rst
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every edge outside reset
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// antecedent in this cycle implies consequent in the same cycle
`define ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// antecedent in this cycle implies consequent in the next cycle
`define ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

/* hw/rtl/ntpodc_pkg.sv */
// ----------------------------------------------------------------------------
// ntpodc_pkg
// shared types and constants of the ntp offset and delay calculator
// ----------------------------------------------------------------------------
`default_nettype none

package ntpodc_pkg;

  // nanoseconds in one second
  localparam logic [29:0] NS_PER_SEC = 30'd1000000000;

  // floor(2^64 / 1e9) = 4 * 2^32 + RECIP_LO
  localparam int unsigned RECIP_HI_SHIFT = 2;
  localparam logic [30:0] RECIP_LO = 31'd1266874889;

  // default depth of the queue between front and back
  localparam int unsigned FIFO_DEPTH = 4;

  // one response that will produce a result
  typedef struct packed {
    logic [31:0] orig_seconds;
    logic [31:0] orig_nanos;
    logic [31:0] recv_seconds;
    logic [31:0] recv_nanos;
    logic [31:0] xmit_seconds;
    logic [31:0] xmit_nanos;
    logic [31:0] local_seconds;
    logic [29:0] local_nanos;
  } job_t;

endpackage

`default_nettype wire

/* hw/rtl/ntpodc_front.sv */
// ----------------------------------------------------------------------------
// ntpodc_front
// accepts responses, drops bad frames, latches arrival time, queues jobs
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ntpodc_front
  import ntpodc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        frame_ok,
  input  wire logic [31:0] orig_seconds,
  input  wire logic [31:0] orig_nanos,
  input  wire logic [31:0] recv_seconds,
  input  wire logic [31:0] recv_nanos,
  input  wire logic [31:0] xmit_seconds,
  input  wire logic [31:0] xmit_nanos,
  input  wire logic [31:0] local_seconds,
  input  wire logic [29:0] local_nanos,
  input  wire logic        full,
  output logic             push,
  output job_t             push_data
);

  logic        stamp_held;
  logic [31:0] held_seconds;
  logic [29:0] held_nanos;
  logic        accept;
  logic        first_resp;

  assign in_stall   = full;
  assign accept     = in_valid && !full;
  assign first_resp = (xmit_seconds == 32'd0);
  assign push       = accept && frame_ok && !first_resp && stamp_held;

  always_comb begin
    push_data.orig_seconds  = orig_seconds;
    push_data.orig_nanos    = orig_nanos;
    push_data.recv_seconds  = recv_seconds;
    push_data.recv_nanos    = recv_nanos;
    push_data.xmit_seconds  = xmit_seconds;
    push_data.xmit_nanos    = xmit_nanos;
    push_data.local_seconds = held_seconds;
    push_data.local_nanos   = held_nanos;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stamp_held <= 1'b0;
    end else if (accept && frame_ok) begin
      if (first_resp) begin
        stamp_held <= 1'b1;
      end else if (stamp_held) begin
        stamp_held <= 1'b0;
      end
    end
  end

  // latched time, no reset: only read while stamp_held is set
  always_ff @(posedge clk) begin
    if (accept && frame_ok && first_resp) begin
      held_seconds <= local_seconds;
      held_nanos   <= local_nanos;
    end
  end

  `ASSERT_IMPL(a_push_needs_stamp, push, stamp_held, "job queued without a latched time")
  `ASSERT_NEXT(a_push_consumes, push, !stamp_held, "latched time not consumed by job")

endmodule

`default_nettype wire

/* hw/rtl/ntpodc_fifo.sv */
// ----------------------------------------------------------------------------
// ntpodc_fifo
// short job queue between front and back
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ntpodc_fifo
  import ntpodc_pkg::*;
#(
  parameter int unsigned DEPTH = FIFO_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t push_data,
  input  wire logic pop,
  output job_t      pop_data,
  output logic      full,
  output logic      empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  job_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  `ASSERT_ALWAYS(a_count_range, count <= CNT_W'(DEPTH), "queue count past depth")

endmodule

`default_nettype wire

/* hw/rtl/ntpodc_frac.sv */
// ----------------------------------------------------------------------------
// ntpodc_frac
// four stage conversion of seconds and nanoseconds to 32.32 fixed point
// ----------------------------------------------------------------------------
`default_nettype none

module ntpodc_frac
  import ntpodc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [31:0] seconds,
  input  wire logic [31:0] nanos,
  output logic      [63:0] fixed
);

  // frac = floor(nanos * 2^32 / 1e9) by reciprocal, estimate is exact or one low
  logic [31:0] sec1, sec2, sec3;
  logic [31:0] nano1;
  logic [62:0] prod1;
  logic [31:0] q0_2, q0_3;
  logic [30:0] m3;
  logic [30:0] rem;
  logic [31:0] q0_sum;

  assign q0_sum = (nano1 << RECIP_HI_SHIFT) + {1'b0, prod1[62:32]};
  assign rem    = 31'd0 - m3;

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1: low part of the reciprocal product
      sec1  <= seconds;
      nano1 <= nanos;
      prod1 <= 63'(nanos) * 63'(RECIP_LO);
      // stage 2: quotient estimate
      sec2  <= sec1;
      q0_2  <= q0_sum;
      // stage 3: low bits of estimate times 1e9
      sec3  <= sec2;
      q0_3  <= q0_2;
      m3    <= 31'(q0_2[30:0] * 31'(NS_PER_SEC));
      // stage 4: remainder check and one step correction
      fixed <= {sec3, (rem >= 31'(NS_PER_SEC)) ? q0_3 + 32'd1 : q0_3};
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/ntpodc_back.sv */
// ----------------------------------------------------------------------------
// ntpodc_back
// eight stage datapath from queued job to delay and offset words
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ntpodc_back
  import ntpodc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire job_t       job,
  input  wire logic       job_empty,
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic signed [63:0] delay_client,
  output logic signed [63:0] delay_server,
  output logic signed [63:0] delay_transit,
  output logic signed [63:0] clock_offset,
  output logic signed [63:0] offset_change
);

  localparam int unsigned NUM_STG = 8;

  logic [NUM_STG:1] stg_v;
  logic             adv;

  logic [63:0] t1, t2, t3, t4;
  logic [63:0] dcli5, dsrv5, d43_5, d12_5;
  logic [63:0] dcli6, dsrv6, sum6, tran6;
  logic [63:0] dcli7, dsrv7, tran7, off7;
  logic [63:0] sum_adj;
  logic [63:0] last_offset;

  // whole pipeline moves when the output register is free
  assign adv       = !stg_v[NUM_STG] || !out_stall;
  assign pop       = adv && !job_empty;
  assign out_valid = stg_v[NUM_STG];

  ntpodc_frac u_frac_orig (
    .clk(clk), .en(adv), .seconds(job.orig_seconds), .nanos(job.orig_nanos), .fixed(t1)
  );
  ntpodc_frac u_frac_recv (
    .clk(clk), .en(adv), .seconds(job.recv_seconds), .nanos(job.recv_nanos), .fixed(t2)
  );
  ntpodc_frac u_frac_xmit (
    .clk(clk), .en(adv), .seconds(job.xmit_seconds), .nanos(job.xmit_nanos), .fixed(t3)
  );
  ntpodc_frac u_frac_local (
    .clk(clk), .en(adv), .seconds(job.local_seconds), .nanos({2'b00, job.local_nanos}),
    .fixed(t4)
  );

  // halve toward zero: add one to a negative sum before the arithmetic shift
  assign sum_adj = sum6 + {63'd0, sum6[63]};

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_v <= '0;
    end else if (adv) begin
      stg_v <= {stg_v[NUM_STG-1:1], pop};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_offset <= '0;
    end else if (adv && stg_v[NUM_STG-1]) begin
      last_offset <= off7;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // stage 5: pairwise differences
      dcli5 <= t4 - t1;
      dsrv5 <= t3 - t2;
      d43_5 <= t4 - t3;
      d12_5 <= t1 - t2;
      // stage 6: offset sum and transit
      dcli6 <= dcli5;
      dsrv6 <= dsrv5;
      sum6  <= d43_5 + d12_5;
      tran6 <= dcli5 - dsrv5;
      // stage 7: signed halving
      dcli7 <= dcli6;
      dsrv7 <= dsrv6;
      tran7 <= tran6;
      off7  <= {sum_adj[63], sum_adj[63:1]};
      // stage 8: output register
      delay_client  <= dcli7;
      delay_server  <= dsrv7;
      delay_transit <= tran7;
      clock_offset  <= off7;
      offset_change <= off7 - last_offset;
    end
  end

  `ASSERT_NEXT(a_last_off_hold, !(adv && stg_v[NUM_STG-1]), $stable(last_offset),
               "previous offset changed without a result")
  `ASSERT_NEXT(a_pipe_freeze, stg_v[NUM_STG] && out_stall, $stable(stg_v),
               "pipeline moved while output stalled")

endmodule

`default_nettype wire

/* hw/rtl/ntp_offset_delay_calc.sv */
// ----------------------------------------------------------------------------
// ntp_offset_delay_calc
// ntp clock offset and round trip delay from one received response
// ----------------------------------------------------------------------------
// A response word is taken in any cycle in which the job queue has room, so
// words can arrive back to back. Bad frames are dropped, a response with zero
// transmit seconds latches the local arrival time, and the next good response
// with nonzero transmit seconds (if a time is latched) is queued as a job.
// A queued job is written into the queue at the accepting edge, moves into
// the first of eight datapath stages when the back end pops it, and raises
// out_valid in the eighth, the output register. The back end retires one job
// per cycle when not stalled; the rate is set by out_stall, as the whole
// datapath holds when a full output register is stalled, and by queue depth.
// ----------------------------------------------------------------------------
`default_nettype none

module ntp_offset_delay_calc
  import ntpodc_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = FIFO_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input words
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        frame_ok,
  input  wire logic [31:0] orig_seconds,
  input  wire logic [31:0] orig_nanos,
  input  wire logic [31:0] recv_seconds,
  input  wire logic [31:0] recv_nanos,
  input  wire logic [31:0] xmit_seconds,
  input  wire logic [31:0] xmit_nanos,
  input  wire logic [31:0] local_seconds,
  input  wire logic [29:0] local_nanos,
  // result words, all signed 32.32 seconds
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic signed [63:0] delay_client,
  output logic signed [63:0] delay_server,
  output logic signed [63:0] delay_transit,
  output logic signed [63:0] clock_offset,
  output logic signed [63:0] offset_change
);

  job_t q_push_data;
  job_t q_pop_data;
  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;

  // front: classify words and hold the latched arrival time
  ntpodc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .frame_ok     (frame_ok),
    .orig_seconds (orig_seconds),
    .orig_nanos   (orig_nanos),
    .recv_seconds (recv_seconds),
    .recv_nanos   (recv_nanos),
    .xmit_seconds (xmit_seconds),
    .xmit_nanos   (xmit_nanos),
    .local_seconds(local_seconds),
    .local_nanos  (local_nanos),
    .full         (q_full),
    .push         (q_push),
    .push_data    (q_push_data)
  );

  // queue: each job carries its own copy of the latched time
  ntpodc_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_data(q_push_data),
    .pop      (q_pop),
    .pop_data (q_pop_data),
    .full     (q_full),
    .empty    (q_empty)
  );

  // back: fixed point conversion, differences, halving, offset change
  ntpodc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .job          (q_pop_data),
    .job_empty    (q_empty),
    .pop          (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .delay_client (delay_client),
    .delay_server (delay_server),
    .delay_transit(delay_transit),
    .clock_offset (clock_offset),
    .offset_change(offset_change)
  );

endmodule

`default_nettype wire
